/* rtl/tsv_pkg.sv */
`default_nettype none

package tsv_pkg;

  localparam int VALUE_WIDTH = 24;
  localparam int FRAC_BITS   = 8;
  localparam int NUM_CHAN    = 3;
  localparam int CHAN_W      = 2;
  localparam int TIME_W      = 32;
  localparam int TMO_W       = 16;
  localparam int SUM_W       = VALUE_WIDTH + 2;
  localparam int DIFF_W      = VALUE_WIDTH + 3;
  localparam int SCL_W       = VALUE_WIDTH + 8;

  localparam logic [TMO_W-1:0]  TIMEOUT_RESET = 16'd1000;
  localparam logic              REQ_SAMPLE    = 1'b0;
  localparam logic              REQ_CHECK     = 1'b1;
  localparam logic [CHAN_W-1:0] CHAN_INVALID  = 2'd3;

  typedef enum logic [1:0] {
    VOTE_UNANIMOUS  = 2'd0,
    VOTE_MAJORITY   = 2'd1,
    VOTE_DISAGREE   = 2'd2,
    VOTE_ALL_FAILED = 2'd3
  } vote_code_t;

  typedef struct packed {
    logic                          req_type;
    logic [CHAN_W-1:0]             channel;
    logic signed [VALUE_WIDTH-1:0] value;
    logic [TIME_W-1:0]             time_ms;
  } tsv_in_t;

  typedef struct packed {
    logic signed [VALUE_WIDTH-1:0] fused_value;
    vote_code_t                    vote_status;
    logic [NUM_CHAN-1:0]           failed_mask;
    logic                          rejected;
  } tsv_out_t;

endpackage

`default_nettype wire

/* rtl/tmr_sensor_voter.sv */
`default_nettype none

// Triple-redundant sensor voter. Each input transfer either stores a reading
// and timestamp for one channel (marking it healthy) or runs a timeout check
// that fails every healthy channel older than timeout_ms; both then re-vote
// (median of three, floor mean of two, single value degraded, zero when all
// failed) and give exactly one result transfer. A sample naming channel 3 is
// rejected, changes no state and repeats the last vote. The block takes one
// item every clock cycle while out_ready is high; each input transfer passes
// through the input register, one register-to-register pass through the
// update and vote logic, and the result register, and a stalled result holds
// the next item in the input register. cfg_ready is always high; write
// timeout_ms only while the block is idle.
module tmr_sensor_voter (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_valid,
  output logic                        in_ready,
  input  wire tsv_pkg::tsv_in_t       in_data,
  output logic                        out_valid,
  input  wire logic                   out_ready,
  output tsv_pkg::tsv_out_t           out_data,
  input  wire logic                   cfg_valid,
  output logic                        cfg_ready,
  input  wire logic [tsv_pkg::TMO_W-1:0] cfg_data
);

  localparam int VW = tsv_pkg::VALUE_WIDTH;
  localparam int NC = tsv_pkg::NUM_CHAN;
  localparam int SW = tsv_pkg::SUM_W;
  localparam int XW = tsv_pkg::DIFF_W;
  localparam int DW = tsv_pkg::SCL_W;
  localparam int CW = tsv_pkg::CHAN_W;
  localparam int TW = tsv_pkg::TIME_W;

  logic                           in_v_r;
  tsv_pkg::tsv_in_t               in_r;
  logic                           out_v_r;
  tsv_pkg::tsv_out_t              out_r;
  tsv_pkg::tsv_out_t              out_nxt;
  logic signed [VW-1:0]           rd_r   [NC];
  logic signed [VW-1:0]           rd_nxt [NC];
  logic [tsv_pkg::TIME_W-1:0]     st_r   [NC];
  logic [tsv_pkg::TIME_W-1:0]     st_nxt [NC];
  logic [NC-1:0]                  fail_r;
  logic [NC-1:0]                  fail_nxt;
  logic signed [VW-1:0]           last_val_r;
  tsv_pkg::vote_code_t            last_code_r;
  logic [tsv_pkg::TMO_W-1:0]      tmo_r;

  logic                           advance;
  logic                           is_sample;
  logic                           rej;
  logic [tsv_pkg::TIME_W-1:0]     age;
  logic [NC-1:0]                  ok;
  logic [1:0]                     n;
  logic signed [SW-1:0]           sum;
  logic [SW-1:0]                  thr;
  logic signed [XW-1:0]           x;
  logic signed [XW-1:0]           nv;
  logic signed [XW-1:0]           diff;
  logic [XW-1:0]                  mag;
  logic [DW-1:0]                  scaled;
  logic                           disagree;
  logic signed [VW-1:0]           min_ab;
  logic signed [VW-1:0]           max_ab;
  logic signed [VW-1:0]           mid_c;
  logic signed [VW-1:0]           median;
  logic signed [SW-1:0]           half;
  logic signed [VW-1:0]           vote_val;
  tsv_pkg::vote_code_t            vote_code;

  assign advance   = in_v_r && (!out_v_r || out_ready);
  assign in_ready  = !in_v_r || advance;
  assign out_valid = out_v_r;
  assign out_data  = out_r;
  assign cfg_ready = 1'b1;

  // channel state update
  always_comb begin
    is_sample = (in_r.req_type == tsv_pkg::REQ_SAMPLE);
    rej       = is_sample && (in_r.channel == tsv_pkg::CHAN_INVALID);
    age       = '0;
    for (int i = 0; i < NC; i++) begin
      rd_nxt[i]   = rd_r[i];
      st_nxt[i]   = st_r[i];
      fail_nxt[i] = fail_r[i];
      age         = in_r.time_ms - st_r[i];
      if (is_sample) begin
        if (!rej && (in_r.channel == CW'(i))) begin
          rd_nxt[i]   = in_r.value;
          st_nxt[i]   = in_r.time_ms;
          fail_nxt[i] = 1'b0;
        end
      end else if (!fail_r[i] && (age > TW'(tmo_r))) begin
        fail_nxt[i] = 1'b1;
      end
    end
  end

  // vote over healthy channels
  always_comb begin
    ok  = ~fail_nxt;
    n   = {1'b0, ok[0]} + {1'b0, ok[1]} + {1'b0, ok[2]};
    sum = '0;
    for (int i = 0; i < NC; i++) begin
      if (ok[i]) begin
        sum = sum + SW'(rd_nxt[i]);
      end
    end
    if (sum > 0) begin
      thr = sum;
    end else begin
      thr = SW'(n) << tsv_pkg::FRAC_BITS;
    end
    disagree = 1'b0;
    x        = '0;
    nv       = '0;
    diff     = '0;
    mag      = '0;
    scaled   = '0;
    for (int i = 0; i < NC; i++) begin
      x = XW'(rd_nxt[i]);
      case (n)
        2'd3:    nv = x + (x <<< 1);
        2'd2:    nv = x <<< 1;
        default: nv = x;
      endcase
      diff   = nv - XW'(sum);
      mag    = (diff < 0) ? XW'(-diff) : XW'(diff);
      scaled = DW'({mag, 4'b0}) + DW'({mag, 2'b0});
      if (ok[i] && (scaled > DW'(thr))) begin
        disagree = 1'b1;
      end
    end
    min_ab = (rd_nxt[0] < rd_nxt[1]) ? rd_nxt[0] : rd_nxt[1];
    max_ab = (rd_nxt[0] < rd_nxt[1]) ? rd_nxt[1] : rd_nxt[0];
    mid_c  = (max_ab < rd_nxt[2]) ? max_ab : rd_nxt[2];
    median = (min_ab > mid_c) ? min_ab : mid_c;
    half   = sum >>> 1;
    case (n)
      2'd0: begin
        vote_val  = '0;
        vote_code = tsv_pkg::VOTE_ALL_FAILED;
      end
      2'd1: begin
        vote_val  = ok[0] ? rd_nxt[0] : (ok[1] ? rd_nxt[1] : rd_nxt[2]);
        vote_code = tsv_pkg::VOTE_DISAGREE;
      end
      2'd2: begin
        vote_val  = half[VW-1:0];
        vote_code = disagree ? tsv_pkg::VOTE_DISAGREE : tsv_pkg::VOTE_MAJORITY;
      end
      default: begin
        vote_val  = median;
        vote_code = disagree ? tsv_pkg::VOTE_DISAGREE : tsv_pkg::VOTE_UNANIMOUS;
      end
    endcase
    out_nxt.fused_value = rej ? last_val_r : vote_val;
    out_nxt.vote_status = rej ? last_code_r : vote_code;
    out_nxt.failed_mask = fail_nxt;
    out_nxt.rejected    = rej;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r      <= 1'b0;
      out_v_r     <= 1'b0;
      fail_r      <= '0;
      last_val_r  <= '0;
      last_code_r <= tsv_pkg::VOTE_UNANIMOUS;
      tmo_r       <= tsv_pkg::TIMEOUT_RESET;
      for (int i = 0; i < NC; i++) begin
        rd_r[i] <= '0;
        st_r[i] <= '0;
      end
    end else begin
      if (in_ready) begin
        in_v_r <= in_valid;
      end
      if (advance) begin
        out_v_r <= 1'b1;
        fail_r  <= fail_nxt;
        for (int i = 0; i < NC; i++) begin
          rd_r[i] <= rd_nxt[i];
          st_r[i] <= st_nxt[i];
        end
        if (!rej) begin
          last_val_r  <= vote_val;
          last_code_r <= vote_code;
        end
      end else if (out_ready) begin
        out_v_r <= 1'b0;
      end
      if (cfg_valid) begin
        tmo_r <= cfg_data;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_r <= in_data;
    end
    if (advance) begin
      out_r <= out_nxt;
    end
  end

endmodule

`default_nettype wire

/* rtl/tsv_checker.sv */
`default_nettype none

module tsv_checker (
  input wire logic                   clk,
  input wire logic                   rst_n,
  input wire logic                   out_valid,
  input wire logic                   out_ready,
  input wire tsv_pkg::tsv_out_t      out_data
);

  // stalled result transfer holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // all-failed code comes with zero value and full mask
  a_all_failed: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.vote_status == tsv_pkg::VOTE_ALL_FAILED) |->
      (out_data.fused_value == '0) && (out_data.failed_mask == 3'b111))
    else $error("all-failed code inconsistent");

  a_mask_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.failed_mask == 3'b111) |->
      (out_data.vote_status == tsv_pkg::VOTE_ALL_FAILED))
    else $error("no healthy channel but vote given");

  a_unanimous: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.vote_status == tsv_pkg::VOTE_UNANIMOUS) |->
      (out_data.failed_mask == 3'b000))
    else $error("unanimous with failed channel");

  a_majority: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.vote_status == tsv_pkg::VOTE_MAJORITY) |->
      ($countones(out_data.failed_mask) == 1))
    else $error("majority without exactly two healthy channels");

endmodule

bind tmr_sensor_voter tsv_checker u_tsv_checker (.*);

`default_nettype wire

/* bench/tb_tmr_sensor_voter.sv */
`timescale 1ns / 1ps

module tb_tmr_sensor_voter;

  localparam int VALUE_WIDTH = tsv_pkg::VALUE_WIDTH;
  localparam int FRAC_BITS   = tsv_pkg::FRAC_BITS;
  localparam int NUM_CHAN    = tsv_pkg::NUM_CHAN;
  localparam int CHAN_W      = tsv_pkg::CHAN_W;
  localparam int TIME_W      = tsv_pkg::TIME_W;
  localparam int TMO_W       = tsv_pkg::TMO_W;

  localparam logic signed [VALUE_WIDTH-1:0] VAL_MAX = {1'b0, {(VALUE_WIDTH-1){1'b1}}};
  localparam logic signed [VALUE_WIDTH-1:0] VAL_MIN = {1'b1, {(VALUE_WIDTH-1){1'b0}}};

  logic clk = 1'b0;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  tsv_pkg::tsv_in_t in_data;
  logic out_valid;
  logic out_ready = 1'b0;
  tsv_pkg::tsv_out_t out_data;
  logic cfg_valid;
  logic cfg_ready;
  logic [TMO_W-1:0] cfg_data;

  tmr_sensor_voter i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always #10 clk = ~clk;

  // predicted voter state
  logic signed [VALUE_WIDTH-1:0] chan_val [NUM_CHAN];
  logic [TIME_W-1:0] chan_time [NUM_CHAN];
  logic [NUM_CHAN-1:0] chan_dead;
  logic signed [VALUE_WIDTH-1:0] vote_val;
  tsv_pkg::vote_code_t vote_code;
  logic [TMO_W-1:0] tmo_ms;

  tsv_pkg::tsv_out_t vote_q[$];
  int unsigned err_cnt = 0;
  int unsigned n_in = 0;
  int unsigned n_out = 0;
  int unsigned n_cfg = 0;
  int unsigned n_rej = 0;
  int unsigned code_cnt [4] = '{0, 0, 0, 0};
  int unsigned rdy_hold = 0;
  bit calm = 1'b0;
  logic [TIME_W-1:0] now_ms = '0;

  function automatic void revote();
    longint signed v [NUM_CHAN];
    longint signed s, thr, d, lo, hi, med;
    int n;
    bit dis;
    n = 0;
    s = 0;
    dis = 1'b0;
    for (int i = 0; i < NUM_CHAN; i++) begin
      if (!chan_dead[i]) begin
        v[n] = longint'(chan_val[i]);
        s += v[n];
        n++;
      end
    end
    if (n == 0) begin
      vote_val = '0;
      vote_code = tsv_pkg::VOTE_ALL_FAILED;
    end else if (n == 1) begin
      vote_val = v[0][VALUE_WIDTH-1:0];
      vote_code = tsv_pkg::VOTE_DISAGREE;
    end else begin
      // 5 percent relative, or 0.05 absolute when the sum is not positive
      thr = (s > 0) ? s : (longint'(n) <<< FRAC_BITS);
      for (int i = 0; i < n; i++) begin
        d = n * v[i] - s;
        if (d < 0) d = -d;
        if (20 * d > thr) dis = 1'b1;
      end
      if (n == 3) begin
        lo = (v[0] < v[1]) ? v[0] : v[1];
        hi = (v[0] < v[1]) ? v[1] : v[0];
        med = (v[2] < lo) ? lo : ((v[2] > hi) ? hi : v[2]);
      end else begin
        med = s >>> 1;
      end
      vote_val = med[VALUE_WIDTH-1:0];
      if (dis) vote_code = tsv_pkg::VOTE_DISAGREE;
      else if (n == 3) vote_code = tsv_pkg::VOTE_UNANIMOUS;
      else vote_code = tsv_pkg::VOTE_MAJORITY;
    end
  endfunction

  function automatic tsv_pkg::tsv_out_t predict_vote(tsv_pkg::tsv_in_t it);
    tsv_pkg::tsv_out_t r;
    logic [TIME_W-1:0] age;
    r.rejected = 1'b0;
    if (it.req_type == tsv_pkg::REQ_SAMPLE) begin
      if (it.channel == tsv_pkg::CHAN_INVALID) begin
        r.rejected = 1'b1;
      end else begin
        chan_val[it.channel] = it.value;
        chan_time[it.channel] = it.time_ms;
        chan_dead[it.channel] = 1'b0;
        revote();
      end
    end else begin
      for (int i = 0; i < NUM_CHAN; i++) begin
        age = it.time_ms - chan_time[i];
        if (!chan_dead[i] && age > TIME_W'(tmo_ms)) chan_dead[i] = 1'b1;
      end
      revote();
    end
    r.fused_value = vote_val;
    r.vote_status = vote_code;
    r.failed_mask = chan_dead;
    return r;
  endfunction

  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return $urandom_range(1, 2);
    if (r < 93) return $urandom_range(3, 8);
    return $urandom_range(20, 60);
  endfunction

  function automatic longint signed pick_base();
    logic [31:0] w;
    w = $urandom;
    case ($urandom_range(0, 3))
      0: return longint'($urandom_range(0, 4000)) - 2000;
      1: return longint'($signed(w[VALUE_WIDTH-1:0]));
      2: return longint'(VAL_MAX) - longint'($urandom_range(0, 100));
      default: return longint'(VAL_MIN) + longint'($urandom_range(0, 100));
    endcase
  endfunction

  // checks each result transfer, then predicts from each input transfer
  always @(posedge clk) begin
    tsv_pkg::tsv_out_t exp_r;
    if (!rst_n) begin
      for (int i = 0; i < NUM_CHAN; i++) begin
        chan_val[i] = '0;
        chan_time[i] = '0;
      end
      chan_dead = '0;
      vote_val = '0;
      vote_code = tsv_pkg::VOTE_UNANIMOUS;
      tmo_ms = tsv_pkg::TIMEOUT_RESET;
    end else begin
      if (cfg_valid && cfg_ready) begin
        tmo_ms = cfg_data;
        n_cfg++;
      end
      if (out_valid && out_ready) begin
        n_out++;
        if (vote_q.size() == 0) begin
          $error("result transfer with no vote expected");
          err_cnt++;
        end else begin
          exp_r = vote_q.pop_front();
          if (out_data.fused_value !== exp_r.fused_value) begin
            $error("fused_value: expected %0d, got %0d", exp_r.fused_value,
                   out_data.fused_value);
            err_cnt++;
          end
          if (out_data.vote_status !== exp_r.vote_status) begin
            $error("vote_status: expected %0d, got %0d", exp_r.vote_status,
                   out_data.vote_status);
            err_cnt++;
          end
          if (out_data.failed_mask !== exp_r.failed_mask) begin
            $error("failed_mask: expected %b, got %b", exp_r.failed_mask,
                   out_data.failed_mask);
            err_cnt++;
          end
          if (out_data.rejected !== exp_r.rejected) begin
            $error("rejected: expected %0d, got %0d", exp_r.rejected, out_data.rejected);
            err_cnt++;
          end
          code_cnt[exp_r.vote_status]++;
          if (exp_r.rejected) n_rej++;
        end
      end
      if (in_valid && in_ready) begin
        vote_q.push_back(predict_vote(in_data));
        n_in++;
      end
    end
  end

  // result side back-pressure
  always @(negedge clk) begin
    if (rdy_hold != 0) begin
      rdy_hold--;
    end else if (out_ready && !calm && $urandom_range(0, 2) == 0) begin
      out_ready <= 1'b0;
      rdy_hold = idle_len();
    end else begin
      out_ready <= 1'b1;
      rdy_hold = $urandom_range(0, 12);
    end
  end

  task automatic send_item(input logic req, input logic [CHAN_W-1:0] ch,
                           input logic signed [VALUE_WIDTH-1:0] val,
                           input logic [TIME_W-1:0] t);
    tsv_pkg::tsv_in_t it;
    int unsigned gap;
    it.req_type = req;
    it.channel = ch;
    it.value = val;
    it.time_ms = t;
    gap = (calm || $urandom_range(0, 1) == 0) ? 0 : idle_len();
    @(negedge clk);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic wait_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (vote_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_timeout(input logic [TMO_W-1:0] v);
    wait_idle();
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic test_startup_and_reject();
    send_item(tsv_pkg::REQ_CHECK, 2'd0, '0, 32'd0);
    send_item(tsv_pkg::REQ_SAMPLE, tsv_pkg::CHAN_INVALID, VAL_MAX, 32'hFFFF_FFFF);
    // check ignores channel and value
    send_item(tsv_pkg::REQ_CHECK, tsv_pkg::CHAN_INVALID, -24'sd1, 32'd0);
  endtask

  task automatic test_value_extremes();
    send_item(tsv_pkg::REQ_SAMPLE, 2'd0, VAL_MAX, 32'd0);
    send_item(tsv_pkg::REQ_SAMPLE, 2'd1, VAL_MAX, 32'd0);
    send_item(tsv_pkg::REQ_SAMPLE, 2'd2, VAL_MAX, 32'd0);
    send_item(tsv_pkg::REQ_SAMPLE, 2'd1, VAL_MIN, 32'd0);
    send_item(tsv_pkg::REQ_SAMPLE, 2'd0, VAL_MIN, 32'd0);
    send_item(tsv_pkg::REQ_SAMPLE, 2'd2, VAL_MIN, 32'd0);
  endtask

  task automatic test_disagree_threshold();
    // positive sum: exactly on the 5 percent edge, then one past it
    send_item(tsv_pkg::REQ_SAMPLE, 2'd0, 24'sd130, 32'd0);
    send_item(tsv_pkg::REQ_SAMPLE, 2'd1, 24'sd130, 32'd0);
    send_item(tsv_pkg::REQ_SAMPLE, 2'd2, 24'sd140, 32'd0);
    send_item(tsv_pkg::REQ_SAMPLE, 2'd2, 24'sd141, 32'd0);
    // non-positive sum: absolute threshold
    send_item(tsv_pkg::REQ_SAMPLE, 2'd0, 24'sd0, 32'd0);
    send_item(tsv_pkg::REQ_SAMPLE, 2'd1, 24'sd0, 32'd0);
    send_item(tsv_pkg::REQ_SAMPLE, 2'd2, -24'sd19, 32'd0);
    send_item(tsv_pkg::REQ_SAMPLE, 2'd2, -24'sd20, 32'd0);
  endtask

  task automatic test_timeout_and_wrap();
    send_item(tsv_pkg::REQ_CHECK, 2'd0, '0, 32'd1000);
    send_item(tsv_pkg::REQ_SAMPLE, 2'd0, 24'sd256, 32'd500);
    send_item(tsv_pkg::REQ_CHECK, 2'd0, '0, 32'd1001);
    send_item(tsv_pkg::REQ_CHECK, 2'd0, '0, 32'd1501);
    send_item(tsv_pkg::REQ_SAMPLE, 2'd1, -24'sd3, 32'hFFFF_FFF0);
    send_item(tsv_pkg::REQ_SAMPLE, 2'd2, 24'sd0, 32'hFFFF_FFF0);
    // age wraps through zero
    send_item(tsv_pkg::REQ_CHECK, 2'd0, '0, 32'd984);
    send_item(tsv_pkg::REQ_CHECK, 2'd0, '0, 32'd985);
  endtask

  task automatic test_random_traffic(input int unsigned n_items, input logic [TMO_W-1:0] tmo,
                                     input bit quiet);
    longint signed base, m, x;
    int unsigned r;
    logic [CHAN_W-1:0] ch;
    logic signed [VALUE_WIDTH-1:0] val;
    write_timeout(tmo);
    calm = quiet;
    base = pick_base();
    for (int k = 0; k < n_items; k++) begin
      if ($urandom_range(0, 39) == 0) base = pick_base();
      r = $urandom_range(0, 99);
      if (r < 8) begin
        send_item(1'($urandom_range(0, 1)), CHAN_W'($urandom_range(0, 3)),
                  VALUE_WIDTH'($urandom), $urandom);
      end else if (r < 62) begin
        ch = ($urandom_range(0, 19) == 0) ? tsv_pkg::CHAN_INVALID
                                          : CHAN_W'($urandom_range(0, 2));
        case ($urandom_range(0, 3))
          0: m = 0;
          1: m = ((base < 0) ? -base : base) / 32 + 2;
          default: m = ((base < 0) ? -base : base) / 8 + 8;
        endcase
        x = base + longint'($urandom_range(0, 32'(2 * m))) - m;
        if (x > VAL_MAX) x = VAL_MAX;
        if (x < VAL_MIN) x = VAL_MIN;
        val = ($urandom_range(0, 9) == 0) ? VALUE_WIDTH'($urandom) : x[VALUE_WIDTH-1:0];
        now_ms += $urandom_range(0, tmo / 8 + 1);
        send_item(tsv_pkg::REQ_SAMPLE, ch, val, now_ms);
      end else begin
        r = $urandom_range(0, 9);
        if (r < 6) now_ms += $urandom_range(0, tmo / 2 + 1);
        else if (r < 9) now_ms += tmo + $urandom_range(0, 2) - 1;
        else now_ms += $urandom;
        send_item(tsv_pkg::REQ_CHECK, CHAN_W'($urandom_range(0, 3)),
                  VALUE_WIDTH'($urandom), now_ms);
      end
    end
  endtask

  initial begin
    logic [TMO_W-1:0] tmo;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    cfg_valid = 1'b0;
    cfg_data = '0;
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;

    test_startup_and_reject();
    test_value_extremes();
    test_disagree_threshold();
    test_timeout_and_wrap();

    test_random_traffic(117, '0, 1'b0);
    test_random_traffic(117, '1, 1'b1);
    test_random_traffic(117, 16'd1, 1'b0);
    for (int p = 3; p < 13; p++) begin
      tmo = ($urandom_range(0, 2) == 0) ? TMO_W'($urandom_range(1, 40))
                                        : TMO_W'($urandom_range(0, 65535));
      test_random_traffic(117, tmo, (p % 4) == 3);
    end

    wait_idle();
    repeat (6) @(posedge clk);
    $display("covered %0d input and %0d result transfers across %0d timeout settings",
             n_in, n_out, n_cfg);
    $display("votes: unanimous %0d, majority %0d, disagree/degraded %0d",
             code_cnt[0], code_cnt[1], code_cnt[2]);
    $display("       all failed %0d, rejected %0d", code_cnt[3], n_rej);
    if (err_cnt == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #20000000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

/* filelist.f */
rtl/tsv_pkg.sv
rtl/tmr_sensor_voter.sv
rtl/tsv_checker.sv
bench/tb_tmr_sensor_voter.sv
